/* hw/rtl/cps_pkg.sv */
// Shared constants for the segment closest-point unit.
// Configuration register indexes and threshold widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;

  localparam int ZT_BITS        = 36;
  localparam int PT_BITS        = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 36;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ZERO_LEN = 2'd0,
    REG_PARALLEL = 2'd1
  } cfg_reg_t;

endpackage
`default_nettype wire

/* hw/rtl/cps_mul.sv */
// Two-stage signed multiplier: operand b split in halves, partials then sum.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module cps_mul #(
  parameter int WA = 36,
  parameter int WB = 36
) (
  input  wire logic                     clk,
  input  wire logic signed [WA-1:0]     a,
  input  wire logic signed [WB-1:0]     b,
  output logic signed [WA+WB-1:0]       p
);

  localparam int H = WB / 2;

  logic signed [WA+H:0]        pp_lo;
  logic signed [WA+WB-H-1:0]   pp_hi;

  always_ff @(posedge clk) begin
    pp_lo <= a * $signed({1'b0, b[H-1:0]});
    pp_hi <= a * $signed(b[WB-1:H]);
    p     <= ((WA+WB)'(pp_hi) <<< H) + (WA+WB)'(pp_lo);
  end

endmodule
`default_nettype wire

/* hw/rtl/cps_div.sv */
// Pipelined restoring divider, one quotient bit per stage, result clamped
// to [0, 2^(QB-1)]. Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module cps_div #(
  parameter int NW = 52,
  parameter int DW = 36,
  parameter int QB = 17
) (
  input  wire logic          clk,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic          zero,
  output logic      [QB-1:0] q
);

  localparam int CW = NW + DW + QB;
  localparam logic [QB-1:0] ONE = QB'(1) << (QB - 1);

  logic [NW-1:0] rem_r  [0:QB-1];
  logic [DW-1:0] den_r  [0:QB-1];
  logic [QB-1:0] q_r    [0:QB];
  logic          zero_r [0:QB];
  logic          sat_r  [0:QB];

  always_ff @(posedge clk) begin
    rem_r[0]  <= num;
    den_r[0]  <= den;
    q_r[0]    <= '0;
    zero_r[0] <= zero | (den == '0);
    sat_r[0]  <= CW'(num) >= (CW'(den) << QB);
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [CW:0] dsh;
    logic [CW:0] diff;
    assign dsh  = (CW+1)'(den_r[j]) << K;
    assign diff = (CW+1)'(rem_r[j]) - dsh;

    always_ff @(posedge clk) begin
      zero_r[j+1] <= zero_r[j];
      sat_r[j+1]  <= sat_r[j];
      if (!diff[CW]) begin
        q_r[j+1] <= q_r[j] | (QB'(1) << K);
      end else begin
        q_r[j+1] <= q_r[j];
      end
    end

    if (j + 1 < QB) begin : g_carry
      always_ff @(posedge clk) begin
        den_r[j+1] <= den_r[j];
        if (!diff[CW]) begin
          rem_r[j+1] <= diff[NW-1:0];
        end else begin
          rem_r[j+1] <= rem_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (zero_r[QB]) begin
      q <= '0;
    end else if (sat_r[QB] || (q_r[QB] > ONE)) begin
      q <= ONE;
    end else begin
      q <= q_r[QB];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/cps_delay.sv */
// Fixed-length delay line with synchronous clear.
// Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none
module cps_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] st [0:N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) begin
        st[i] <= '0;
      end
    end else begin
      st[0] <= d;
      for (int i = 1; i < N; i++) begin
        st[i] <= st[i-1];
      end
    end
  end

  assign q = st[N-1];

endmodule
`default_nettype wire

/* hw/rtl/closest_points_between_segments_unit.sv */
// Top level: closest-point parameters s, t of two 3D segments, fully pipelined.
// Depends on cps_pkg, cps_mul, cps_div, cps_delay.
//
//   channel | signals                                   | dir | flow
//   item    | start, busy, a_*/b_* coordinates          | in  | start & !busy
//   result  | done, s_param, t_param                    | out | done, one cycle
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in  | valid & ready
//
// One item per cycle; each result follows its beat through the two chained
// dividers of FRAC_BITS+1 quotient stages each.
// busy is high only during reset; cfg_ready is always high.
// rst clears valid bits and restores both thresholds to 1.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
`default_nettype none
module closest_points_between_segments_unit
  import cps_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [COORD_BITS-1:0] a_start_x,
  input  wire logic signed [COORD_BITS-1:0] a_start_y,
  input  wire logic signed [COORD_BITS-1:0] a_start_z,
  input  wire logic signed [COORD_BITS-1:0] a_end_x,
  input  wire logic signed [COORD_BITS-1:0] a_end_y,
  input  wire logic signed [COORD_BITS-1:0] a_end_z,
  input  wire logic signed [COORD_BITS-1:0] b_start_x,
  input  wire logic signed [COORD_BITS-1:0] b_start_y,
  input  wire logic signed [COORD_BITS-1:0] b_start_z,
  input  wire logic signed [COORD_BITS-1:0] b_end_x,
  input  wire logic signed [COORD_BITS-1:0] b_end_y,
  input  wire logic signed [COORD_BITS-1:0] b_end_z,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]    cfg_data,
  output logic                             done,
  output logic      [FRAC_BITS:0]          s_param,
  output logic      [FRAC_BITS:0]          t_param
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int MW  = 2 * SW;
  localparam int NW0 = MW + 1;
  localparam int QB  = FRAC_BITS + 1;
  localparam int L   = FRAC_BITS + 3;
  localparam int TW  = SW + FRAC_BITS + 3;
  localparam int ZCW = (SW > ZT_BITS) ? SW : ZT_BITS;
  localparam int LAT = 13 + 2 * L;
  localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

  // configuration
  logic [ZT_BITS-1:0] zt;
  logic [PT_BITS-1:0] pt;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      zt <= ZT_BITS'(1);
      pt <= PT_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ZERO_LEN: zt <= cfg_data[ZT_BITS-1:0];
        REG_PARALLEL: pt <= cfg_data[PT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // R0: capture
  logic signed [COORD_BITS-1:0] pas [3];
  logic signed [COORD_BITS-1:0] pae [3];
  logic signed [COORD_BITS-1:0] pbs [3];
  logic signed [COORD_BITS-1:0] pbe [3];
  logic v0, v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    pas[0] <= a_start_x; pas[1] <= a_start_y; pas[2] <= a_start_z;
    pae[0] <= a_end_x;   pae[1] <= a_end_y;   pae[2] <= a_end_z;
    pbs[0] <= b_start_x; pbs[1] <= b_start_y; pbs[2] <= b_start_z;
    pbe[0] <= b_end_x;   pbe[1] <= b_end_y;   pbe[2] <= b_end_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else begin
      v0 <= start & ~busy;
      v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  // R1: direction vectors
  logic signed [DW-1:0] d1 [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [DW-1:0] rr [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1[i] <= DW'(pae[i]) - DW'(pas[i]);
      d2[i] <= DW'(pbe[i]) - DW'(pbs[i]);
      rr[i] <= DW'(pas[i]) - DW'(pbs[i]);
    end
  end

  // R2: products
  logic signed [PW-1:0] p_a [3];
  logic signed [PW-1:0] p_e [3];
  logic signed [PW-1:0] p_b [3];
  logic signed [PW-1:0] p_c [3];
  logic signed [PW-1:0] p_f [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_a[i] <= d1[i] * d1[i];
      p_e[i] <= d2[i] * d2[i];
      p_b[i] <= d1[i] * d2[i];
      p_c[i] <= d1[i] * rr[i];
      p_f[i] <= d2[i] * rr[i];
    end
  end

  // R3: dot products
  logic signed [SW-1:0] dot_a, dot_e, dot_b, dot_c, dot_f;

  always_ff @(posedge clk) begin
    dot_a <= SW'(p_a[0]) + SW'(p_a[1]) + SW'(p_a[2]);
    dot_e <= SW'(p_e[0]) + SW'(p_e[1]) + SW'(p_e[2]);
    dot_b <= SW'(p_b[0]) + SW'(p_b[1]) + SW'(p_b[2]);
    dot_c <= SW'(p_c[0]) + SW'(p_c[1]) + SW'(p_c[2]);
    dot_f <= SW'(p_f[0]) + SW'(p_f[1]) + SW'(p_f[2]);
  end

  // R4..R5: wide products
  logic signed [MW-1:0] m_ae, m_bb, m_bf, m_ce;

  cps_mul #(.WA(SW), .WB(SW)) u_mul_ae (.clk, .a(dot_a), .b(dot_e), .p(m_ae));
  cps_mul #(.WA(SW), .WB(SW)) u_mul_bb (.clk, .a(dot_b), .b(dot_b), .p(m_bb));
  cps_mul #(.WA(SW), .WB(SW)) u_mul_bf (.clk, .a(dot_b), .b(dot_f), .p(m_bf));
  cps_mul #(.WA(SW), .WB(SW)) u_mul_ce (.clk, .a(dot_c), .b(dot_e), .p(m_ce));

  logic signed [SW-1:0] a4, b4, c4, e4, f4;
  logic adeg4, edeg4;

  always_ff @(posedge clk) begin
    a4    <= dot_a; b4 <= dot_b; c4 <= dot_c; e4 <= dot_e; f4 <= dot_f;
    adeg4 <= ZCW'($unsigned(dot_a)) < ZCW'(zt);
    edeg4 <= ZCW'($unsigned(dot_e)) < ZCW'(zt);
  end

  localparam int S6W = 5 * SW + 3;
  logic [S6W-1:0] side6;
  logic signed [SW-1:0] a6, b6, c6, e6, f6;
  logic adeg6, edeg6, v6;

  cps_delay #(.W(S6W), .N(2)) u_dly6 (
    .clk, .rst, .d({a4, b4, c4, e4, f4, adeg4, edeg4, v4}), .q(side6)
  );
  assign {a6, b6, c6, e6, f6, adeg6, edeg6, v6} = side6;

  // R6: denominator and numerator of s
  logic signed [NW0-1:0] denom6, snum6;

  always_ff @(posedge clk) begin
    denom6 <= NW0'(m_ae) - NW0'(m_bb);
    snum6  <= NW0'(m_bf) - NW0'(m_ce);
  end

  // R7: divider operands
  logic [NW0-1:0] dmag, nmag;
  logic           par, s0z_c, sAz_c, sBz_c;
  logic signed [SW:0] bc;

  always_comb begin
    dmag  = denom6[NW0-1] ? $unsigned(-denom6) : $unsigned(denom6);
    nmag  = snum6[NW0-1]  ? $unsigned(-snum6)  : $unsigned(snum6);
    par   = dmag < NW0'(pt);
    s0z_c = par | (snum6 == '0) | (denom6 == '0) | (snum6[NW0-1] != denom6[NW0-1]);
    sAz_c = ~c6[SW-1] | (a6 == '0);
    bc    = (SW+1)'(b6) - (SW+1)'(c6);
    sBz_c = bc[SW] | (bc == '0) | (a6 == '0);
  end

  logic [NW0+FRAC_BITS-1:0] s0n7;
  logic [NW0-1:0]           s0d7;
  logic [SW+FRAC_BITS-1:0]  sAn7, sBn7;
  logic [SW-1:0]            ad7;
  logic                     s0z7, sAz7, sBz7;
  logic signed [SW-1:0]     b7, e7, f7;
  logic                     adeg7, edeg7, v7;

  always_ff @(posedge clk) begin
    s0n7  <= {nmag, {FRAC_BITS{1'b0}}};
    s0d7  <= dmag;
    s0z7  <= s0z_c;
    sAn7  <= {$unsigned(-c6), {FRAC_BITS{1'b0}}};
    sBn7  <= {bc[SW-1:0], {FRAC_BITS{1'b0}}};
    ad7   <= $unsigned(a6);
    sAz7  <= sAz_c;
    sBz7  <= sBz_c;
    b7    <= b6; e7 <= e6; f7 <= f6;
    adeg7 <= adeg6; edeg7 <= edeg6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else begin
      v7 <= v6;
    end
  end

  logic [QB-1:0] s0q, sAq, sBq;

  cps_div #(.NW(NW0+FRAC_BITS), .DW(NW0), .QB(QB)) u_div_s0 (
    .clk, .num(s0n7), .den(s0d7), .zero(s0z7), .q(s0q)
  );
  cps_div #(.NW(SW+FRAC_BITS), .DW(SW), .QB(QB)) u_div_sa (
    .clk, .num(sAn7), .den(ad7), .zero(sAz7), .q(sAq)
  );
  cps_div #(.NW(SW+FRAC_BITS), .DW(SW), .QB(QB)) u_div_sb (
    .clk, .num(sBn7), .den(ad7), .zero(sBz7), .q(sBq)
  );

  localparam int SXW = 3 * SW + 3;
  logic [SXW-1:0] sidex;
  logic signed [SW-1:0] bx, ex, fx;
  logic adegx, edegx, vx;

  cps_delay #(.W(SXW), .N(L)) u_dlyx (
    .clk, .rst, .d({b7, e7, f7, adeg7, edeg7, v7}), .q(sidex)
  );
  assign {bx, ex, fx, adegx, edegx, vx} = sidex;

  // tn = b*s + f*ONE
  logic [QB-1:0]              sq;
  logic signed [SW+QB:0]      m_bs;

  assign sq = adegx ? '0 : s0q;

  cps_mul #(.WA(SW), .WB(QB+1)) u_mul_bs (
    .clk, .a(bx), .b($signed({1'b0, sq})), .p(m_bs)
  );

  localparam int SYW = 2 * SW + 3 + 3 * QB;
  logic [SYW-1:0] sidey;
  logic signed [SW-1:0] ey, fy;
  logic adegy, edegy, vy;
  logic [QB-1:0] s0y, sAy, sBy;

  cps_delay #(.W(SYW), .N(2)) u_dlyy (
    .clk, .rst, .d({ex, fx, adegx, edegx, vx, s0q, sAq, sBq}), .q(sidey)
  );
  assign {ey, fy, adegy, edegy, vy, s0y, sAy, sBy} = sidey;

  logic signed [TW-1:0] tn3;
  logic signed [SW-1:0] e3;
  logic adeg3, edeg3, v3x;
  logic [QB-1:0] s03, sA3, sB3;

  always_ff @(posedge clk) begin
    tn3   <= TW'(m_bs) + (TW'(fy) <<< FRAC_BITS);
    e3    <= ey;
    adeg3 <= adegy; edeg3 <= edegy;
    s03   <= s0y; sA3 <= sAy; sB3 <= sBy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3x <= 1'b0;
    end else begin
      v3x <= vy;
    end
  end

  // t divider operands and range flags
  logic [TW-1:0]  tn4;
  logic [SW-1:0]  e4d;
  logic           tz4, tneg4, tgt4, adeg4b, edeg4b, v4b;
  logic [QB-1:0]  s04, sA4, sB4;

  always_ff @(posedge clk) begin
    tn4    <= $unsigned(tn3);
    e4d    <= $unsigned(e3);
    tz4    <= tn3[TW-1] | (tn3 == '0) | (e3 == '0);
    tneg4  <= tn3[TW-1];
    tgt4   <= tn3 > (TW'(e3) <<< FRAC_BITS);
    adeg4b <= adeg3; edeg4b <= edeg3;
    s04    <= s03; sA4 <= sA3; sB4 <= sB3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4b <= 1'b0;
    end else begin
      v4b <= v3x;
    end
  end

  logic [QB-1:0] tq;

  cps_div #(.NW(TW), .DW(SW), .QB(QB)) u_div_t (
    .clk, .num(tn4), .den(e4d), .zero(tz4), .q(tq)
  );

  localparam int SZW = 5 + 3 * QB;
  logic [SZW-1:0] sidez;
  logic tnegz, tgtz, adegz, edegz, vz;
  logic [QB-1:0] s0z, sAz, sBz;

  cps_delay #(.W(SZW), .N(L)) u_dlyz (
    .clk, .rst, .d({tneg4, tgt4, adeg4b, edeg4b, v4b, s04, sA4, sB4}), .q(sidez)
  );
  assign {tnegz, tgtz, adegz, edegz, vz, s0z, sAz, sBz} = sidez;

  // result select
  always_ff @(posedge clk) begin
    if (adegz && edegz) begin
      s_param <= '0;  t_param <= '0;
    end else if (adegz) begin
      s_param <= '0;  t_param <= tq;
    end else if (edegz || tnegz) begin
      s_param <= sAz; t_param <= '0;
    end else if (tgtz) begin
      s_param <= sBz; t_param <= ONE;
    end else begin
      s_param <= s0z; t_param <= tq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vz;
    end
  end

  // checks
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (s_param <= ONE) && (t_param <= ONE))
    else $error("result parameter above one");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("beat did not produce a result on time");

  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching beat");

endmodule
`default_nettype wire
